// File: src/srli_pkg.sv
// ----------------------------------------------------------------------------
// srli_pkg
// Shared types, sizes and codes for the ring log index unit.
// ----------------------------------------------------------------------------
package srli_pkg;

    // sizes
    localparam int SLOTS     = 64;
    localparam int VALUE_MAX = 32;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int SLOT_FW   = 6;
    localparam int COUNT_FW  = 7;
    localparam int SEQ_W     = 32;
    localparam int MAP_W     = (IDX_W > SLOT_FW) ? IDX_W : SLOT_FW;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

    // operation codes
    typedef enum logic [2:0] {
        OP_LOAD_BEGIN = 3'd0,
        OP_SCAN       = 3'd1,
        OP_LOAD_END   = 3'd2,
        OP_APPEND     = 3'd3,
        OP_READ       = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_SHF_RD,
        ST_SHF_WR,
        ST_RD_DATA,
        ST_END_DATA,
        ST_DONE
    } core_state_t;

    // one map entry: sequence and physical slot of a logical position
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [MAP_W-1:0] slot;
    } map_entry_t;

    // one input item
    typedef struct packed {
        logic [2:0]         operation;
        logic [5:0]         entry_index;
        logic [SEQ_W-1:0]   record_sequence;
        logic [SLOT_FW-1:0] record_slot;
        logic               record_ok;
        logic [7:0]         event_class;
        logic [7:0]         value_length;
        logic               storage_ok;
    } item_t;

    // one result item
    typedef struct packed {
        logic                success;
        logic [SLOT_FW-1:0]  slot;
        logic [SLOT_FW-1:0]  logical_position;
        logic [SEQ_W-1:0]    sequence_used;
        logic [COUNT_FW-1:0] entry_count;
        logic                log_exists;
        logic [SLOT_FW-1:0]  public_write_index;
    } result_t;

    // slot number plus one, wrapping at the ring size
    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] r;
        if (s == LAST_IDX)
        begin
            r = '0;
        end
        else
        begin
            r = s + 1'b1;
        end
        return r;
    endfunction

endpackage

// File: src/srli_ram.sv
// ----------------------------------------------------------------------------
// srli_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module srli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/srli_core.sv
// ----------------------------------------------------------------------------
// srli_core
// Sequencer and index state: walks the map memory one entry per step with a
// single sequence comparator for sorted insert, full-log shift and lookups.
// ----------------------------------------------------------------------------
module srli_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  srli_pkg::item_t             item,
    input  logic                        accept,
    output logic                        ready,
    input  logic                        out_free,
    output logic                        done,
    output srli_pkg::result_t           result,
    output logic                        mem_wr_en,
    output logic [srli_pkg::IDX_W-1:0]  mem_wr_addr,
    output srli_pkg::map_entry_t        mem_wr_data,
    output logic                        mem_rd_en,
    output logic [srli_pkg::IDX_W-1:0]  mem_rd_addr,
    input  srli_pkg::map_entry_t        mem_rd_data
);

    import srli_pkg::*;

    core_state_t      state_reg, state_next;
    item_t            item_reg, item_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic [SEQ_W-1:0] next_sequence_reg, next_sequence_next;
    logic [IDX_W-1:0] write_slot_reg, write_slot_next;
    logic             exists_flag_reg, exists_flag_next;

    logic             res_success_reg, res_success_next;
    logic [MAP_W-1:0] res_slot_reg, res_slot_next;
    logic [IDX_W-1:0] res_pos_reg, res_pos_next;
    logic             res_appended_reg, res_appended_next;
    logic [SEQ_W-1:0] res_seq_reg, res_seq_next;

    logic             append_now;
    logic [IDX_W-1:0] append_pos;
    logic             count_full;
    logic             seq_greater;
    logic             append_ok;
    logic             scan_ok;
    logic             read_ok;
    logic [SEQ_W-1:0] seq_out;

    // sequence compare unit and request checks
    assign count_full  = (held_count_reg >= SLOTS_CNT);
    assign seq_greater = (mem_rd_data.seq > item_reg.record_sequence);
    assign append_ok   = (item.event_class != '0)
                         && (int'(item.value_length) <= VALUE_MAX)
                         && item.storage_ok;
    assign scan_ok     = item.record_ok && (int'(item.record_slot) < SLOTS) && !count_full;
    assign read_ok     = (int'(item.entry_index) < int'(held_count_reg))
                         && (int'(item.entry_index) < SLOTS);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            held_count_reg    <= '0;
            next_sequence_reg <= '0;
            write_slot_reg    <= '0;
            exists_flag_reg   <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            held_count_reg    <= held_count_next;
            next_sequence_reg <= next_sequence_next;
            write_slot_reg    <= write_slot_next;
            exists_flag_reg   <= exists_flag_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        k_reg            <= k_next;
        res_success_reg  <= res_success_next;
        res_slot_reg     <= res_slot_next;
        res_pos_reg      <= res_pos_next;
        res_appended_reg <= res_appended_next;
        res_seq_reg      <= res_seq_next;
    end

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        item_next          = item_reg;
        k_next             = k_reg;
        held_count_next    = held_count_reg;
        next_sequence_next = next_sequence_reg;
        write_slot_next    = write_slot_reg;
        exists_flag_next   = exists_flag_reg;
        res_success_next   = res_success_reg;
        res_slot_next      = res_slot_reg;
        res_pos_next       = res_pos_reg;
        res_appended_next  = res_appended_reg;
        res_seq_next       = res_seq_reg;
        mem_wr_en          = 1'b0;
        mem_wr_addr        = k_reg;
        mem_wr_data        = mem_rd_data;
        mem_rd_en          = 1'b0;
        mem_rd_addr        = k_reg;
        append_now         = 1'b0;
        append_pos         = k_reg;
        done               = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next         = item;
                    res_success_next  = 1'b0;
                    res_slot_next     = '0;
                    res_pos_next      = '0;
                    res_appended_next = 1'b0;
                    state_next        = ST_DONE;
                    case (op_t'(item.operation))
                        OP_LOAD_BEGIN:
                        begin
                            held_count_next    = '0;
                            next_sequence_next = '0;
                            write_slot_next    = '0;
                            exists_flag_next   = 1'b0;
                            res_success_next   = 1'b1;
                        end
                        OP_SCAN:
                        begin
                            if (scan_ok)
                            begin
                                k_next     = IDX_W'(held_count_reg);
                                state_next = ST_INS_RD;
                            end
                        end
                        OP_LOAD_END:
                        begin
                            res_success_next = 1'b1;
                            if (held_count_reg != '0)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = IDX_W'(held_count_reg - 1'b1);
                                state_next  = ST_END_DATA;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (append_ok)
                            begin
                                if (count_full)
                                begin
                                    k_next     = '0;
                                    state_next = ST_SHF_RD;
                                end
                                else
                                begin
                                    append_now      = 1'b1;
                                    append_pos      = IDX_W'(held_count_reg);
                                    held_count_next = held_count_reg + 1'b1;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (read_ok)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = IDX_W'(item.entry_index);
                                state_next  = ST_RD_DATA;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (item.storage_ok)
                            begin
                                held_count_next    = '0;
                                next_sequence_next = '0;
                                write_slot_next    = '0;
                                exists_flag_next   = 1'b0;
                                res_success_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_success_next = 1'b0;
                        end
                    endcase
                end
            end

            // fetch the entry below the hole, or drop the record at the bottom
            ST_INS_RD:
            begin
                if (k_reg == '0)
                begin
                    mem_wr_en        = 1'b1;
                    mem_wr_addr      = k_reg;
                    mem_wr_data.seq  = item_reg.record_sequence;
                    mem_wr_data.slot = MAP_W'(item_reg.record_slot);
                    held_count_next  = held_count_reg + 1'b1;
                    res_success_next = 1'b1;
                    state_next       = ST_DONE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = k_reg - 1'b1;
                    state_next  = ST_INS_CMP;
                end
            end

            // larger sequences move up one place, equal ones stay below
            ST_INS_CMP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = k_reg;
                if (seq_greater)
                begin
                    mem_wr_data = mem_rd_data;
                    k_next      = k_reg - 1'b1;
                    state_next  = ST_INS_RD;
                end
                else
                begin
                    mem_wr_data.seq  = item_reg.record_sequence;
                    mem_wr_data.slot = MAP_W'(item_reg.record_slot);
                    held_count_next  = held_count_reg + 1'b1;
                    res_success_next = 1'b1;
                    state_next       = ST_DONE;
                end
            end

            // full log: shift every entry down one place, then append on top
            ST_SHF_RD:
            begin
                if (k_reg == LAST_IDX)
                begin
                    append_now = 1'b1;
                    append_pos = LAST_IDX;
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = k_reg + 1'b1;
                    state_next  = ST_SHF_WR;
                end
            end

            ST_SHF_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = k_reg;
                mem_wr_data = mem_rd_data;
                k_next      = k_reg + 1'b1;
                state_next  = ST_SHF_RD;
            end

            // read lookup
            ST_RD_DATA:
            begin
                res_slot_next    = mem_rd_data.slot;
                res_success_next = 1'b1;
                state_next       = ST_DONE;
            end

            // newest entry sets sequence and write slot
            ST_END_DATA:
            begin
                next_sequence_next = mem_rd_data.seq + 1'b1;
                write_slot_next    = slot_inc(IDX_W'(mem_rd_data.slot));
                exists_flag_next   = 1'b1;
                state_next         = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // common append commit
        if (append_now)
        begin
            mem_wr_en          = 1'b1;
            mem_wr_addr        = append_pos;
            mem_wr_data.seq    = next_sequence_reg;
            mem_wr_data.slot   = MAP_W'(write_slot_reg);
            res_slot_next      = MAP_W'(write_slot_reg);
            res_pos_next       = append_pos;
            res_seq_next       = next_sequence_reg;
            res_appended_next  = 1'b1;
            res_success_next   = 1'b1;
            exists_flag_next   = 1'b1;
            next_sequence_next = next_sequence_reg + 1'b1;
            write_slot_next    = slot_inc(write_slot_reg);
            state_next         = ST_DONE;
        end
    end

    // result fields
    assign seq_out = res_appended_reg ? res_seq_reg : next_sequence_reg;
    assign ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        result.success            = res_success_reg;
        result.slot               = res_slot_reg[SLOT_FW-1:0];
        result.logical_position   = SLOT_FW'(res_pos_reg);
        result.sequence_used      = seq_out;
        result.entry_count        = COUNT_FW'(held_count_reg);
        result.log_exists         = exists_flag_reg;
        result.public_write_index = count_full ? '0 : SLOT_FW'(held_count_reg);
    end

`ifndef NO_ASSERTIONS
    // count never passes the ring size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= SLOTS_CNT)
        else $error("held count above ring size");

    // insert compare never runs at the bottom position
    a_ins_k: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INS_CMP |-> k_reg != '0)
        else $error("insert compare at position zero");

    // a delivered result always returns the sequencer to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == ST_IDLE)
        else $error("sequencer not idle after result");

    // an item is only taken while idle, and work starts on the next cycle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted item produced no work");

    // the map only grows by one entry per item
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != $past(held_count_reg) && held_count_reg != '0
        |-> held_count_reg == $past(held_count_reg) + 1'b1)
        else $error("held count jumped");
`endif

endmodule

// File: src/sequenced_ring_log_index_unit.sv
// ----------------------------------------------------------------------------
// sequenced_ring_log_index_unit
// Logical-to-physical slot map of a ring log: sorted load, append, read,
// clear. The map lives in a small memory walked by one sequencer.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------
//   in      | input     | in_valid / in_stall | operation .. storage_ok
//   out     | output    | out_valid/out_stall | success .. public_write_index
//
// one item at a time; in_stall is high from acceptance until its result is registered
// load begin, clear, rejected items, in-place append: straight to the result;
// read, non-empty load end: one map read first; scan insert: a read and a write per
// larger entry moved; full-log append, longest insert: walk the map one entry per step
// reset empties the map through the count register; no clearing pass
// a stalled result holds in the output register while the next item runs
//
module sequenced_ring_log_index_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [5:0]  entry_index,
    input  logic [31:0] record_sequence,
    input  logic [5:0]  record_slot,
    input  logic        record_ok,
    input  logic [7:0]  event_class,
    input  logic [7:0]  value_length,
    input  logic        storage_ok,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        success,
    output logic [5:0]  slot,
    output logic [5:0]  logical_position,
    output logic [31:0] sequence_used,
    output logic [6:0]  entry_count,
    output logic        log_exists,
    output logic [5:0]  public_write_index
);

    import srli_pkg::*;

    item_t            item;
    result_t          core_result;
    result_t          result_reg;
    logic             out_valid_reg, out_valid_next;
    logic             core_ready;
    logic             core_done;
    logic             accept;
    logic             out_free;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    map_entry_t       mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    map_entry_t       mem_rd_data;

    // input item
    always_comb
    begin
        item.operation       = operation;
        item.entry_index     = entry_index;
        item.record_sequence = record_sequence;
        item.record_slot     = record_slot;
        item.record_ok       = record_ok;
        item.event_class     = event_class;
        item.value_length    = value_length;
        item.storage_ok      = storage_ok;
    end

    assign in_stall = !core_ready;
    assign accept   = in_valid && core_ready;
    assign out_free = !out_valid_reg || !out_stall;

    // sequencer
    srli_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .accept      (accept),
        .ready       (core_ready),
        .out_free    (out_free),
        .done        (core_done),
        .result      (core_result),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // map memory
    srli_ram #(
        .WIDTH ($bits(map_entry_t)),
        .DEPTH (SLOTS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign success            = result_reg.success;
    assign slot               = result_reg.slot;
    assign logical_position   = result_reg.logical_position;
    assign sequence_used      = result_reg.sequence_used;
    assign entry_count        = result_reg.entry_count;
    assign log_exists         = result_reg.log_exists;
    assign public_write_index = result_reg.public_write_index;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks sequenced_ring_log_index_unit against a cycle-free model of the ring
// log slot map. A directed opening covers empty, rejected, wrapping and
// tie-breaking cases, then random load sessions, append and read streams,
// clears and stray codes run with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srli_pkg::*;

    // operation codes the block leaves unused
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int ITEM_TARGET  = 2000;
    localparam int CALM_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PRINT_LIMIT  = 40;

    // model of the slot map plus the queue of results still owed by the block
    class slot_map_tracker;
        logic [5:0]  map_slot [SLOTS];
        logic [31:0] map_seq [SLOTS];
        int unsigned held;
        logic [31:0] next_seq;
        logic [5:0]  write_slot;
        logic        log_live;
        result_t     awaited[$];
        int          errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < SLOTS; i++)
            begin
                map_slot[i] = '0;
                map_seq[i]  = '0;
            end
            held       = 0;
            next_seq   = '0;
            write_slot = '0;
            log_live   = 1'b0;
        endfunction

        // place a scanned record after every entry of lower or equal sequence
        function bit insert_sorted(logic [31:0] seq, logic [5:0] s);
            int unsigned pos;
            if (held >= SLOTS)
            begin
                return 1'b0;
            end
            pos = held;
            while (pos > 0 && map_seq[pos-1] > seq)
            begin
                pos--;
            end
            for (int unsigned k = held; k > pos; k--)
            begin
                map_seq[k]  = map_seq[k-1];
                map_slot[k] = map_slot[k-1];
            end
            map_seq[pos]  = seq;
            map_slot[pos] = s;
            held++;
            return 1'b1;
        endfunction

        // apply one accepted item and queue the result it must produce
        function logic note_accepted(item_t it);
            result_t     r;
            logic        appended;
            int unsigned pos;
            r        = '0;
            appended = 1'b0;
            case (it.operation)
                OP_LOAD_BEGIN:
                begin
                    wipe();
                    r.success = 1'b1;
                end
                OP_SCAN:
                begin
                    if (it.record_ok && int'(it.record_slot) < SLOTS)
                    begin
                        r.success = insert_sorted(it.record_sequence, it.record_slot);
                    end
                end
                OP_LOAD_END:
                begin
                    if (held > 0)
                    begin
                        next_seq   = map_seq[held-1] + 32'd1;
                        write_slot = 6'((int'(map_slot[held-1]) + 1) % SLOTS);
                        log_live   = 1'b1;
                    end
                    r.success = 1'b1;
                end
                OP_APPEND:
                begin
                    if (it.event_class != 8'd0 && int'(it.value_length) <= VALUE_MAX
                        && it.storage_ok)
                    begin
                        // a full log drops its oldest entry
                        if (held < SLOTS)
                        begin
                            pos = held;
                            held++;
                        end
                        else
                        begin
                            pos = SLOTS - 1;
                            for (int unsigned k = 0; k < pos; k++)
                            begin
                                map_slot[k] = map_slot[k+1];
                                map_seq[k]  = map_seq[k+1];
                            end
                        end
                        map_slot[pos]      = write_slot;
                        map_seq[pos]       = next_seq;
                        r.slot             = write_slot;
                        r.logical_position = 6'(pos);
                        r.sequence_used    = next_seq;
                        appended           = 1'b1;
                        log_live           = 1'b1;
                        next_seq           = next_seq + 32'd1;
                        write_slot         = 6'((int'(write_slot) + 1) % SLOTS);
                        r.success          = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (it.entry_index < held)
                    begin
                        r.slot    = map_slot[it.entry_index];
                        r.success = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    if (it.storage_ok)
                    begin
                        wipe();
                        r.success = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (!appended)
            begin
                r.sequence_used = next_seq;
            end
            r.entry_count        = 7'(held);
            r.log_exists         = log_live;
            r.public_write_index = (held >= SLOTS) ? 6'd0 : 6'(held);
            awaited.push_back(r);
            return r.success;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
            begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("%s got %0h want %0h", name, got, want));
            end
        endtask

        task check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                report("result with no item outstanding");
                return;
            end
            want = awaited.pop_front();
            compare_field("success", 32'(got.success), 32'(want.success));
            compare_field("slot", 32'(got.slot), 32'(want.slot));
            compare_field("logical_position", 32'(got.logical_position),
                          32'(want.logical_position));
            compare_field("sequence_used", got.sequence_used, want.sequence_used);
            compare_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
            compare_field("log_exists", 32'(got.log_exists), 32'(want.log_exists));
            compare_field("public_write_index", 32'(got.public_write_index),
                          32'(want.public_write_index));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  operation;
    logic [5:0]  entry_index;
    logic [31:0] record_sequence;
    logic [5:0]  record_slot;
    logic        record_ok;
    logic [7:0]  event_class;
    logic [7:0]  value_length;
    logic        storage_ok;
    logic        out_valid;
    logic        out_stall;
    logic        success;
    logic [5:0]  slot;
    logic [5:0]  logical_position;
    logic [31:0] sequence_used;
    logic [6:0]  entry_count;
    logic        log_exists;
    logic [5:0]  public_write_index;

    slot_map_tracker tracker;
    int items_counted;
    int in_idle_odds;
    bit calm;
    int cycle_count;

    sequenced_ring_log_index_unit u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .operation          (operation),
        .entry_index        (entry_index),
        .record_sequence    (record_sequence),
        .record_slot        (record_slot),
        .record_ok          (record_ok),
        .event_class        (event_class),
        .value_length       (value_length),
        .storage_ok         (storage_ok),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .success            (success),
        .slot               (slot),
        .logical_position   (logical_position),
        .sequence_used      (sequence_used),
        .entry_count        (entry_count),
        .log_exists         (log_exists),
        .public_write_index (public_write_index)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.check_result({success, slot, logical_position, sequence_used,
                                  entry_count, log_exists, public_write_index});
        end
    end

    // receiver stall bursts, off near the end of the run
    initial
    begin
        int stall_left;
        int stall_odds;
        stall_left = 0;
        stall_odds = 4;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: stall_odds = 0;
                    1: stall_odds = 3;
                    default: stall_odds = 10;
                endcase
            end
            if (calm)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // every field random, operation as given
    function automatic item_t random_item(logic [2:0] op);
        item_t it;
        it.operation       = op;
        it.entry_index     = 6'($urandom);
        it.record_sequence = $urandom;
        it.record_slot     = 6'($urandom);
        it.record_ok       = 1'($urandom);
        it.event_class     = 8'($urandom);
        it.value_length    = 8'($urandom);
        it.storage_ok      = 1'($urandom);
        return it;
    endfunction

    // present one item, holding it until accepted
    task automatic send_item(item_t it);
        logic ok;
        if (!calm && in_idle_odds != 0 && $urandom_range(0, in_idle_odds - 1) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= it.operation;
        entry_index     <= it.entry_index;
        record_sequence <= it.record_sequence;
        record_slot     <= it.record_slot;
        record_ok       <= it.record_ok;
        event_class     <= it.event_class;
        value_length    <= it.value_length;
        storage_ok      <= it.storage_ok;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        ok = tracker.note_accepted(it);
        // ignored scans and spare codes do not count toward the item total
        if (it.operation <= OP_CLEAR && !(it.operation == OP_SCAN && !ok))
        begin
            items_counted++;
        end
    endtask

    task automatic do_scan(logic [31:0] seq, logic [5:0] s, logic good);
        item_t it;
        it                 = random_item(OP_SCAN);
        it.record_sequence = seq;
        it.record_slot     = s;
        it.record_ok       = good;
        send_item(it);
    endtask

    task automatic do_append(logic [7:0] cls, logic [7:0] len, logic sok);
        item_t it;
        it              = random_item(OP_APPEND);
        it.event_class  = cls;
        it.value_length = len;
        it.storage_ok   = sok;
        send_item(it);
    endtask

    task automatic do_read(logic [5:0] idx);
        item_t it;
        it             = random_item(OP_READ);
        it.entry_index = idx;
        send_item(it);
    endtask

    task automatic do_plain(logic [2:0] op, logic sok);
        item_t it;
        it            = random_item(op);
        it.storage_ok = sok;
        send_item(it);
    endtask

    // stimulus
    initial
    begin
        int          kind;
        int          n;
        int          r;
        int          spread;
        logic [31:0] base;
        tracker         = new();
        items_counted   = 0;
        in_idle_odds    = 0;
        calm            = 1'b0;
        cycle_count     = 0;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        operation       <= '0;
        entry_index     <= '0;
        record_sequence <= '0;
        record_slot     <= '0;
        record_ok       <= 1'b0;
        event_class     <= '0;
        value_length    <= '0;
        storage_ok      <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty log, rejected appends, value length extremes
        do_read(6'd0);
        do_plain(OP_LOAD_END, 1'b1);
        do_append(8'd0, 8'd4, 1'b1);
        do_append(8'd7, 8'(VALUE_MAX + 1), 1'b1);
        do_append(8'd7, 8'd4, 1'b0);
        do_append(8'd255, 8'(VALUE_MAX), 1'b1);
        do_append(8'd1, 8'd0, 1'b1);
        do_read(6'd1);
        do_read(6'd2);
        do_read(6'd63);
        // failed wipe, then a real one
        do_plain(OP_CLEAR, 1'b0);
        do_plain(OP_CLEAR, 1'b1);
        // load with an invalid record, equal sequences and the top sequence
        do_plain(OP_LOAD_BEGIN, 1'b0);
        do_scan(32'd9, 6'd5, 1'b0);
        do_scan(32'hFFFF_FFFF, 6'd63, 1'b1);
        do_scan(32'd5, 6'd10, 1'b1);
        do_scan(32'd5, 6'd20, 1'b1);
        do_scan(32'd0, 6'd0, 1'b1);
        // next sequence and write slot both wrap to zero
        do_plain(OP_LOAD_END, 1'b1);
        do_read(6'd0);
        do_read(6'd2);
        do_read(6'd3);
        do_plain(OP_SPARE_6, 1'b1);
        do_plain(OP_SPARE_7, 1'b0);
        do_append(8'd200, 8'd255, 1'b1);
        do_append(8'd3, 8'd1, 1'b1);
        // scan after the load phase has ended
        do_scan(32'd1, 6'd33, 1'b1);

        // random sessions
        while (items_counted < ITEM_TARGET)
        begin
            calm = (items_counted >= ITEM_TARGET - CALM_ITEMS);
            case ($urandom_range(0, 2))
                0: in_idle_odds = 0;
                1: in_idle_odds = 3;
                default: in_idle_odds = 8;
            endcase
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                // load session, sometimes long enough to fill the map
                do_plain(OP_LOAD_BEGIN, 1'($urandom));
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(62, 80)
                                                : $urandom_range(0, 12);
                case ($urandom_range(0, 3))
                    0: base = 32'hFFFF_FFF0;
                    1: base = 32'd0;
                    default: base = $urandom;
                endcase
                spread = $urandom_range(0, 1) ? 15 : 1000;
                for (int i = 0; i < n; i++)
                begin
                    r = $urandom_range(0, 31);
                    if (r == 0)
                    begin
                        do_read(6'($urandom));
                    end
                    else if (r == 1)
                    begin
                        do_scan($urandom, 6'($urandom), 1'b0);
                    end
                    else if (r == 2)
                    begin
                        do_scan($urandom, 6'($urandom), 1'b1);
                    end
                    else
                    begin
                        do_scan(base + 32'($urandom_range(0, spread)), 6'($urandom), 1'b1);
                    end
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    do_plain(OP_LOAD_END, 1'($urandom));
                end
            end
            else if (kind <= 7)
            begin
                // append and read stream
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100)
                                                : $urandom_range(1, 40);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 9) <= 5)
                    begin
                        case ($urandom_range(0, 17))
                            0: do_append(8'd0, 8'($urandom_range(0, VALUE_MAX)), 1'b1);
                            1: do_append(8'($urandom_range(1, 255)),
                                         8'($urandom_range(VALUE_MAX + 1, 255)), 1'b1);
                            2: do_append(8'($urandom_range(1, 255)),
                                         8'($urandom_range(0, VALUE_MAX)), 1'b0);
                            default: do_append(8'($urandom_range(1, 255)),
                                               8'($urandom_range(0, VALUE_MAX)), 1'b1);
                        endcase
                    end
                    else if (tracker.held > 0 && $urandom_range(0, 1) == 0)
                    begin
                        do_read(6'($urandom_range(0, tracker.held - 1)));
                    end
                    else
                    begin
                        do_read(6'($urandom));
                    end
                end
            end
            else if (kind == 8)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    do_plain(OP_CLEAR, 1'($urandom_range(0, 3) != 0));
                end
                else
                begin
                    do_plain($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, 1'($urandom));
                end
            end
            else
            begin
                // noise: any code, any fields
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    send_item(random_item(3'($urandom)));
                end
            end
        end
        in_valid <= 1'b0;

        // drain
        while (tracker.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
